// File: hdl/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg: shared types and constants for the max-sum path core
// Opcodes, sequencer states and default sizes used by the core.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int LIST_DEPTH_DEF   = 1024;
  localparam int ELEMENT_BITS_DEF = 20;
  localparam int OPCODE_BITS      = 2;
  localparam int TOTAL_BITS       = 31;

  localparam logic [OPCODE_BITS-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OPCODE_BITS-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OPCODE_BITS-1:0] OP_COMPUTE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_STEP,
    ST_PICK
  } msp_state_t;

endpackage

// File: hdl/max_sum_path_two_sorted_lists_core.sv
// Timing: a compute word walks both lists as a merge, each element read into
// the registered read ports and then compared and added, with a pick on the
// shared accumulator at each common value and at the end, before its result word.
// Throughput: one load per cycle while idle; no new word is taken while a walk runs.
// Reset (rst_n low, synchronous): counts, overflow flag, sequencer and
// result valid clear; list memories are left as they are.
// ----------------------------------------------------------------------------
// max_sum_path_two_sorted_lists_core
// Loads two ascending lists and, on compute, walks them as a merge to find
// the maximum path sum, switching lists only at common values.
// ----------------------------------------------------------------------------
module max_sum_path_two_sorted_lists_core
  import msp_pkg::*;
#(
  parameter int LIST_DEPTH   = LIST_DEPTH_DEF,
  parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OPCODE_BITS-1:0]  in_opcode,
  input  logic [ELEMENT_BITS-1:0] in_element,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [TOTAL_BITS-1:0]   out_best_total,
  output logic                    out_overflowed
);

  // Count width holds 0..LIST_DEPTH; address width indexes the memories.
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  // A segment sum never exceeds LIST_DEPTH full-scale elements.
  localparam int SW = ELEMENT_BITS + CW;
  // Adder width for the saturating total.
  localparam int TW = ((SW > TOTAL_BITS) ? SW : TOTAL_BITS) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);
  localparam logic [TW-1:0] TOTAL_MAX_C = TW'({TOTAL_BITS{1'b1}});

  // List memories: one write port (load), one registered read port (walk).
  logic [ELEMENT_BITS-1:0] mem_a [LIST_DEPTH];
  logic [ELEMENT_BITS-1:0] mem_b [LIST_DEPTH];
  logic [ELEMENT_BITS-1:0] rd_a_r;
  logic [ELEMENT_BITS-1:0] rd_b_r;

  msp_state_t state_r, state_nxt;

  logic [CW-1:0]           cnt_a_r, cnt_a_nxt;
  logic [CW-1:0]           cnt_b_r, cnt_b_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [CW-1:0]           i_r, i_nxt;
  logic [CW-1:0]           j_r, j_nxt;
  logic [SW-1:0]           seg_a_r, seg_a_nxt;
  logic [SW-1:0]           seg_b_r, seg_b_nxt;
  logic [TOTAL_BITS-1:0]   total_r, total_nxt;
  logic                    rep_mode_r, rep_mode_nxt;  // absorbing repeats
  logic                    win_a_r, win_a_nxt;        // list A won last common value
  logic                    final_r, final_nxt;        // last pick, then emit
  logic [ELEMENT_BITS-1:0] rep_val_r, rep_val_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [TOTAL_BITS-1:0]   out_total_r, out_total_nxt;
  logic                    out_ovf_r, out_ovf_nxt;

  logic                    in_acc;
  logic                    wr_a, wr_b;
  logic                    has_a, has_b;
  logic [SW-1:0]           va_ext, vb_ext;
  logic [SW-1:0]           seg_max;
  logic [TW-1:0]           add_opnd;
  logic [TW-1:0]           add_sum;
  logic [TOTAL_BITS-1:0]   add_sat;

  // Hold off every word during a walk; hold compute while a result waits.
  always_comb begin
    in_stall = (state_r != ST_IDLE) || (out_valid_r && (in_opcode == OP_COMPUTE));
  end

  assign in_acc = in_valid && !in_stall;
  assign wr_a   = in_acc && (in_opcode == OP_LOAD_A) && (cnt_a_r != DEPTH_C);
  assign wr_b   = in_acc && (in_opcode == OP_LOAD_B) && (cnt_b_r != DEPTH_C);

  assign has_a  = i_r < cnt_a_r;
  assign has_b  = j_r < cnt_b_r;
  assign va_ext = SW'(rd_a_r);
  assign vb_ext = SW'(rd_b_r);
  assign seg_max = (seg_a_r > seg_b_r) ? seg_a_r : seg_b_r;

  // Shared saturating accumulator: operand chosen by the sequencer.
  always_comb begin
    add_opnd = TW'(seg_max);
    if (state_r == ST_STEP) begin
      add_opnd = TW'(win_a_r ? va_ext : vb_ext);
    end
    add_sum = TW'(total_r) + add_opnd;
    add_sat = (add_sum > TOTAL_MAX_C) ? TOTAL_MAX_C[TOTAL_BITS-1:0]
                                      : add_sum[TOTAL_BITS-1:0];
  end

  // Memories: write on load, read the current walk positions every cycle.
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[cnt_a_r[AW-1:0]] <= in_element;
    end
    if (wr_b) begin
      mem_b[cnt_b_r[AW-1:0]] <= in_element;
    end
    rd_a_r <= mem_a[i_r[AW-1:0]];
    rd_b_r <= mem_b[j_r[AW-1:0]];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_opcode == OP_COMPUTE)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        if (rep_mode_r) begin
          // A repeat is taken and re-read; otherwise the read data still
          // matches i and j, so step the merge right away.
          if (win_a_r ? (has_a && (rd_a_r == rep_val_r))
                      : (has_b && (rd_b_r == rep_val_r))) begin
            state_nxt = ST_READ;
          end
        end else if (has_a && has_b && (rd_a_r == rd_b_r)) begin
          state_nxt = ST_PICK;
        end else if (has_a || has_b) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        state_nxt = final_r ? ST_IDLE : ST_READ;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    seg_a_nxt     = seg_a_r;
    seg_b_nxt     = seg_b_r;
    total_nxt     = total_r;
    rep_mode_nxt  = rep_mode_r;
    win_a_nxt     = win_a_r;
    final_nxt     = final_r;
    rep_val_nxt   = rep_val_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_total_nxt = out_total_r;
    out_ovf_nxt   = out_ovf_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_opcode)
            OP_LOAD_A: begin
              if (wr_a) begin
                cnt_a_nxt = cnt_a_r + CW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            OP_LOAD_B: begin
              if (wr_b) begin
                cnt_b_nxt = cnt_b_r + CW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            OP_COMPUTE: begin
              i_nxt        = '0;
              j_nxt        = '0;
              seg_a_nxt    = '0;
              seg_b_nxt    = '0;
              total_nxt    = '0;
              rep_mode_nxt = 1'b0;
              final_nxt    = 1'b0;
            end
            default: begin
              // unused opcode: drop
            end
          endcase
        end
      end
      ST_STEP: begin
        if (rep_mode_r) begin
          if (win_a_r && has_a && (rd_a_r == rep_val_r)) begin
            total_nxt = add_sat;
            i_nxt     = i_r + CW'(1);
          end else if (!win_a_r && has_b && (rd_b_r == rep_val_r)) begin
            total_nxt = add_sat;
            j_nxt     = j_r + CW'(1);
          end else begin
            rep_mode_nxt = 1'b0;
          end
        end else if (has_a && has_b) begin
          if (rd_a_r < rd_b_r) begin
            seg_a_nxt = seg_a_r + va_ext;
            i_nxt     = i_r + CW'(1);
          end else if (rd_a_r > rd_b_r) begin
            seg_b_nxt = seg_b_r + vb_ext;
            j_nxt     = j_r + CW'(1);
          end else begin
            // Common value: close both segments, pick next cycle.
            seg_a_nxt   = seg_a_r + va_ext;
            seg_b_nxt   = seg_b_r + vb_ext;
            i_nxt       = i_r + CW'(1);
            j_nxt       = j_r + CW'(1);
            rep_val_nxt = rd_a_r;
          end
        end else if (has_a) begin
          seg_a_nxt = seg_a_r + va_ext;
          i_nxt     = i_r + CW'(1);
        end else if (has_b) begin
          seg_b_nxt = seg_b_r + vb_ext;
          j_nxt     = j_r + CW'(1);
        end else begin
          final_nxt = 1'b1;
        end
      end
      ST_PICK: begin
        // Add the larger segment; list B wins a tie.
        total_nxt    = add_sat;
        win_a_nxt    = seg_a_r > seg_b_r;
        seg_a_nxt    = '0;
        seg_b_nxt    = '0;
        rep_mode_nxt = !final_r;
        if (final_r) begin
          out_valid_nxt = 1'b1;
          out_total_nxt = add_sat;
          out_ovf_nxt   = ovf_r;
          cnt_a_nxt     = '0;
          cnt_b_nxt     = '0;
          ovf_nxt       = 1'b0;
        end
      end
      default: begin
        // ST_READ: wait for read data
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      rep_mode_r  <= 1'b0;
      final_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      rep_mode_r  <= rep_mode_nxt;
      final_r     <= final_nxt;
    end
  end

  // Walk and result payload registers.
  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    seg_a_r     <= seg_a_nxt;
    seg_b_r     <= seg_b_nxt;
    total_r     <= total_nxt;
    win_a_r     <= win_a_nxt;
    rep_val_r   <= rep_val_nxt;
    out_total_r <= out_total_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_best_total = out_total_r;
  assign out_overflowed = out_ovf_r;

endmodule

// File: bench/tb_max_sum_path_two_sorted_lists_core.sv
// ----------------------------------------------------------------------------
// tb_max_sum_path_two_sorted_lists_core
// Self-checking bench for the max-sum path core. Loads list pairs and issues
// computes through the valid/stall input channel. Predicts each total and
// the drop flag with an independent merge walk, and checks every result word
// in order. Idling and stalling on both channels change from phase to phase.
// ----------------------------------------------------------------------------
module tb_max_sum_path_two_sorted_lists_core;
  import msp_pkg::*;

  localparam int DEPTH = LIST_DEPTH_DEF;
  localparam int EBITS = ELEMENT_BITS_DEF;
  localparam int unsigned ELEM_TOP = (1 << EBITS) - 1;
  localparam longint unsigned TOTAL_CAP = (64'd1 << TOTAL_BITS) - 1;
  // Opcode that the core ignores; no result comes back for it.
  localparam logic [OPCODE_BITS-1:0] OP_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  // Margin after the last total arrives, for the last load or spare word to settle.
  localparam int DRAIN_CYCLES = 16;
  // Load/compute words of short list pairs queued in each idling phase.
  localparam int PHASE_WORDS = 185;

  typedef struct packed {
    logic [OPCODE_BITS-1:0] op;
    logic [EBITS-1:0]       value;
  } word_t;

  typedef struct packed {
    logic [TOTAL_BITS-1:0] best_total;
    logic                  overflowed;
  } total_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [OPCODE_BITS-1:0] in_opcode = OP_LOAD_A;
  logic [EBITS-1:0]       in_element = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [TOTAL_BITS-1:0]  out_best_total;
  logic                   out_overflowed;

  // Stimulus side: words waiting for the driver, and the idling knobs.
  word_t pending_words[$];
  word_t next_word;
  int    words_queued = 0;
  int    idle_pct = 0;
  int    stall_pct = 0;
  logic  word_taken = 1'b0;

  // Staging lists: one pair is built here, then interleaved into words.
  int unsigned stage_a[$];
  int unsigned stage_b[$];

  // Predictor copy of the core: both lists, their fill counts, drop flag.
  logic [EBITS-1:0] path_a[DEPTH];
  logic [EBITS-1:0] path_b[DEPTH];
  int               fill_a = 0;
  int               fill_b = 0;
  logic             drop_seen = 1'b0;
  total_t           totals_due[$];
  total_t           want;

  int fault_count = 0;
  int cycle_count = 0;

  int idle_plan[4]  = '{0, 63, 0, 30};
  int stall_plan[4] = '{0, 0, 63, 30};

  max_sum_path_two_sorted_lists_core #(
    .LIST_DEPTH   (DEPTH),
    .ELEMENT_BITS (EBITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_element     (in_element),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_best_total (out_best_total),
    .out_overflowed (out_overflowed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Walk both lists in merge order. Switch lists only at a common value:
  // take the larger segment (list B on a tie), then swallow the repeats of
  // that value that follow on the winning list alone.
  function automatic longint unsigned best_path_total();
    int               i;
    int               j;
    longint unsigned  total;
    longint unsigned  seg_a;
    longint unsigned  seg_b;
    logic [EBITS-1:0] va;
    logic [EBITS-1:0] vb;
    i = 0;
    j = 0;
    total = 0;
    seg_a = 0;
    seg_b = 0;
    while (i < fill_a && j < fill_b) begin
      va = path_a[i];
      vb = path_b[j];
      if (va < vb) begin
        seg_a += va;
        i++;
      end else if (va > vb) begin
        seg_b += vb;
        j++;
      end else begin
        seg_a += va;
        seg_b += vb;
        i++;
        j++;
        if (seg_a > seg_b) begin
          total += seg_a;
          while (i < fill_a && path_a[i] == va) begin
            total += va;
            i++;
          end
        end else begin
          total += seg_b;
          while (j < fill_b && path_b[j] == vb) begin
            total += vb;
            j++;
          end
        end
        seg_a = 0;
        seg_b = 0;
      end
    end
    // Add whatever tail is left on each list and keep the larger.
    while (i < fill_a) begin
      seg_a += path_a[i];
      i++;
    end
    while (j < fill_b) begin
      seg_b += path_b[j];
      j++;
    end
    total += (seg_a > seg_b) ? seg_a : seg_b;
    return total;
  endfunction

  // Apply one accepted word to the predictor; a compute queues a total.
  function automatic void absorb_word(logic [OPCODE_BITS-1:0] op,
                                      logic [EBITS-1:0] value);
    total_t          due;
    longint unsigned sum;
    case (op)
      OP_LOAD_A: begin
        if (fill_a < DEPTH) begin
          path_a[fill_a] = value;
          fill_a++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      OP_LOAD_B: begin
        if (fill_b < DEPTH) begin
          path_b[fill_b] = value;
          fill_b++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      OP_COMPUTE: begin
        sum = best_path_total();
        if (sum > TOTAL_CAP) sum = TOTAL_CAP;
        due.best_total = sum[TOTAL_BITS-1:0];
        due.overflowed = drop_seen;
        totals_due.push_back(due);
        fill_a = 0;
        fill_b = 0;
        drop_seen = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic void push_word(logic [OPCODE_BITS-1:0] op, int unsigned value);
    word_t w;
    w.op = op;
    w.value = EBITS'(value);
    pending_words.push_back(w);
    // Spare words are ignored by the core; leave them out of the count.
    if (op != OP_SPARE) words_queued++;
  endfunction

  // Build an ascending pair with common values, runs of repeats after a
  // common value, and values clamped at the top of the element range.
  function automatic void stage_sorted(int na, int nb, int unsigned base,
                                       int unsigned stepmax);
    int unsigned v;
    int          roll;
    int          extra;
    v = base;
    stage_a.delete();
    stage_b.delete();
    while (stage_a.size() < na || stage_b.size() < nb) begin
      v = v + $urandom_range(stepmax);
      if (v > ELEM_TOP) v = ELEM_TOP;
      roll = $urandom_range(99);
      if (stage_a.size() >= na) roll = 99;
      else if (stage_b.size() >= nb) roll = 60;
      if (roll < 50) begin
        stage_a.push_back(v);
        stage_b.push_back(v);
        extra = $urandom_range(2);
        repeat (extra) begin
          if ($urandom_range(1) == 1 && stage_a.size() < na) stage_a.push_back(v);
          else if (stage_b.size() < nb) stage_b.push_back(v);
        end
      end else if (roll < 75) begin
        stage_a.push_back(v);
      end else begin
        stage_b.push_back(v);
      end
    end
  endfunction

  function automatic void stage_unsorted(int na, int nb);
    stage_a.delete();
    stage_b.delete();
    repeat (na) stage_a.push_back($urandom_range(ELEM_TOP));
    repeat (nb) stage_b.push_back($urandom_range(ELEM_TOP));
  endfunction

  // Interleave the staged lists into load words at random, sprinkle spare
  // words, and close the set with a compute.
  function automatic void queue_staged(int noise_pct);
    while (stage_a.size() != 0 || stage_b.size() != 0) begin
      if ($urandom_range(99) < noise_pct) push_word(OP_SPARE, $urandom_range(ELEM_TOP));
      if (stage_b.size() == 0 || (stage_a.size() != 0 && $urandom_range(1) == 1))
        push_word(OP_LOAD_A, stage_a.pop_front());
      else
        push_word(OP_LOAD_B, stage_b.pop_front());
    end
    if ($urandom_range(99) < noise_pct) push_word(OP_SPARE, $urandom_range(ELEM_TOP));
    push_word(OP_COMPUTE, $urandom_range(ELEM_TOP));
  endfunction

  // Mostly well-formed short pairs; the rest unsorted, one-sided or noisy.
  function automatic void queue_short_sets(int budget);
    int          target;
    int          roll;
    int unsigned base;
    int unsigned stepmax;
    target = words_queued + budget;
    while (words_queued < target) begin
      roll = $urandom_range(99);
      base = ($urandom_range(1) == 1) ? $urandom_range(ELEM_TOP) : $urandom_range(64);
      stepmax = ($urandom_range(1) == 1) ? $urandom_range(4) : $urandom_range(ELEM_TOP / 8);
      if (roll < 70) stage_sorted($urandom_range(12), $urandom_range(12), base, stepmax);
      else if (roll < 80) stage_unsorted($urandom_range(8), $urandom_range(8));
      else if (roll < 85) stage_sorted($urandom_range(10), 0, base, stepmax);
      else if (roll < 90) stage_sorted(0, $urandom_range(10), base, stepmax);
      else stage_sorted($urandom_range(8), $urandom_range(8), base, stepmax);
      queue_staged((roll >= 90) ? 40 : 3);
    end
  endfunction

  // Driver: present a new word once the last one was taken; hold it
  // otherwise. Drive the receiver stall from the same edge.
  always @(negedge clk) begin
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (!in_valid || word_taken) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_word = pending_words.pop_front();
          in_valid   <= 1'b1;
          in_opcode  <= next_word.op;
          in_element <= next_word.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: sample both handshakes on the rising edge. Feed accepted input
  // words to the predictor, and check result words against the oldest total.
  always @(posedge clk) begin
    if (!rst_n) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) absorb_word(in_opcode, in_element);
      if (out_valid && !out_stall) begin
        if (totals_due.size() == 0) begin
          $error("result word with no total pending: best_total %0d overflowed %0b",
                 out_best_total, out_overflowed);
          fault_count++;
        end else begin
          want = totals_due.pop_front();
          if (out_best_total !== want.best_total) begin
            $error("best_total mismatch: expected %0d, actual %0d",
                   want.best_total, out_best_total);
            fault_count++;
          end
          if (out_overflowed !== want.overflowed) begin
            $error("overflowed mismatch: expected %0b, actual %0b",
                   want.overflowed, out_overflowed);
            fault_count++;
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int phase;

    // Directed words. Compute with both lists empty.
    push_word(OP_COMPUTE, '0);
    // Extremes of the element field on list A alone.
    push_word(OP_LOAD_A, '0);
    push_word(OP_LOAD_A, ELEM_TOP);
    push_word(OP_COMPUTE, ELEM_TOP);
    // List B alone.
    push_word(OP_LOAD_B, 5);
    push_word(OP_LOAD_B, ELEM_TOP);
    push_word(OP_COMPUTE, '0);
    // Common value where list A wins and its repeat follows.
    push_word(OP_LOAD_A, 1);
    push_word(OP_LOAD_A, 3);
    push_word(OP_LOAD_B, 3);
    push_word(OP_LOAD_A, 3);
    push_word(OP_LOAD_B, 3);
    push_word(OP_LOAD_A, 7);
    push_word(OP_LOAD_B, 8);
    push_word(OP_COMPUTE, '0);
    // Tie at a common value: list B wins and takes its repeat.
    push_word(OP_LOAD_A, 3);
    push_word(OP_LOAD_B, 1);
    push_word(OP_SPARE, ELEM_TOP);
    push_word(OP_LOAD_B, 2);
    push_word(OP_LOAD_A, 9);
    push_word(OP_LOAD_B, 9);
    push_word(OP_LOAD_B, 9);
    push_word(OP_COMPUTE, '0);

    // One set with list A at full depth plus one load past the end and a
    // short list B: the last load of list A is dropped and the flag must be
    // reported.
    stage_sorted(DEPTH + 1, 16, 0, 1600);
    queue_staged(0);

    // Hold reset, then release it on a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (phase = 0; phase < 4; phase++) begin
      idle_pct  = idle_plan[phase];
      stall_pct = stall_plan[phase];
      queue_short_sets(PHASE_WORDS);
      while (pending_words.size() != 0) @(posedge clk);
    end

    // Wait for the last word to be taken and the last total to arrive.
    while (in_valid) @(posedge clk);
    while (totals_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fault_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
